FILE: sv/sigtrn_pkg.sv
// Shared widths, register codes and controller/datapath command types for the sigmoid trainer.
package sigtrn_pkg;

    localparam int FEAT_W    = 16;
    localparam int ACT_W     = 16;
    localparam int PARAM_W   = 24;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_A,
        REG_WEIGHT_B,
        REG_OFFSET,
        REG_GAIN
    } reg_idx_t;

    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_MUL_A,
        STEP_MUL_B,
        STEP_SUM,
        STEP_SCALE,
        STEP_FETCH,
        STEP_INTERP,
        STEP_ACT,
        STEP_EMIT,
        STEP_SLOPE,
        STEP_GAIN,
        STEP_SCALE_G,
        STEP_ROUND,
        STEP_UPD_A,
        STEP_UPD_B,
        STEP_UPD_C
    } step_t;

    typedef struct packed {
        logic  load;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic slot_free;
    } status_t;

endpackage

FILE: sv/sigtrn_if.sv
// Sample and result channel interfaces of the sigmoid trainer.
interface sigtrn_in_if import sigtrn_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [FEAT_W-1:0] feature_a;
    logic [FEAT_W-1:0] feature_b;
    logic [FEAT_W-1:0] target;

    modport source (output valid, output mode, output feature_a, output feature_b,
                    output target, input ready);
    modport sink   (input valid, input mode, input feature_a, input feature_b,
                    input target, output ready);
endinterface

interface sigtrn_out_if import sigtrn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] activation;
    logic             decision;

    modport source (output valid, output activation, output decision, input ready);
    modport sink   (input valid, input activation, input decision, output ready);
endinterface

FILE: sv/sigtrn_dp.sv
// Datapath of the sigmoid trainer: one shared multiplier, sigmoid table, weights and result slot.
module sigtrn_dp import sigtrn_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic               in_mode,
    input  logic [FEAT_W-1:0]  in_feature_a,
    input  logic [FEAT_W-1:0]  in_feature_b,
    input  logic [FEAT_W-1:0]  in_target,
    input  logic               cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PARAM_W-1:0] cfg_data,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [ACT_W-1:0]   res_activation,
    output logic               res_decision
);

    localparam int IW = $clog2(DEPTH + 1);
    localparam int TAB_N = 1 << IW;
    localparam logic [24:0] DEPTH_B = 25'(DEPTH);

    // restoring division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], num[i]};
            if (r >= den)
            begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(-16u) in Q1.31: series, then square four times
    function automatic logic [63:0] neg_exp_q31(input logic [63:0] u);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'd1 << 31;
        sum  = 64'd1 << 31;
        for (int n = 1; n <= 14; n++)
        begin
            term = udiv64((term * u) >> 31, 64'(n));
            if ((n % 2) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        for (int n = 0; n < 4; n++)
            sum = (sum * sum) >> 31;
        return sum;
    endfunction

    function automatic logic [ACT_W-1:0] sig_point(input int k, input int d);
        int          a;
        logic [63:0] mag;
        logic [63:0] u;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] s;
        a   = 2 * k - d;
        mag = (a < 0) ? 64'(-a) : 64'(a);
        u   = udiv64(mag << 31, 64'(2 * d));
        e   = neg_exp_q31(u);
        den = (64'd1 << 31) + e;
        if (a >= 0)
            s = udiv64((64'd1 << 47) + (den >> 1), den);
        else
            s = udiv64((e << 16) + (den >> 1), den);
        if (s > 64'd65535)
            s = 64'd65535;
        return s[ACT_W-1:0];
    endfunction

    function automatic logic [PARAM_W-1:0] sat24(input logic [PARAM_W+1:0] v);
        logic [PARAM_W-1:0] r;
        if (v[PARAM_W+1:PARAM_W-1] == 3'b000 || v[PARAM_W+1:PARAM_W-1] == 3'b111)
            r = v[PARAM_W-1:0];
        else if (v[PARAM_W+1])
            r = {1'b1, {(PARAM_W-1){1'b0}}};
        else
            r = {1'b0, {(PARAM_W-1){1'b1}}};
        return r;
    endfunction

    logic [ACT_W-1:0] sig_tab [0:TAB_N-1];

    for (genvar gk = 0; gk < TAB_N; gk++)
    begin : g_tab
        if (gk <= DEPTH)
        begin : g_pt
            localparam logic [ACT_W-1:0] PT = sig_point(gk, DEPTH);
            assign sig_tab[gk] = PT;
        end
        else
        begin : g_pad
            assign sig_tab[gk] = '0;
        end
    end

    // state
    logic [PARAM_W-1:0] w0_reg, w1_reg, off_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic               out_valid_reg;

    // working registers
    logic [FEAT_W-1:0]  fa_reg, fb_reg, tg_reg;
    logic               mode_reg;
    logic signed [62:0] prod_reg;
    logic [41:0]        acc_reg;
    logic               below_reg, above_reg;
    logic [ACT_W-1:0]   lo_reg, diff_reg, frac_reg, act_reg;
    logic [20:0]        err_reg;
    logic [14:0]        slope_reg;
    logic [34:0]        g_reg;
    logic [ACT_W-1:0]   out_act_reg;
    logic               out_dec_reg;

    logic signed [37:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [62:0] prod_next;

    logic [41:0]        off_shift;
    logic               in_range;
    logic [IW-1:0]      tab_k, tab_k1;
    logic [ACT_W-1:0]   act_next;
    logic [62:0]        g_rnd, w_rnd;
    logic [35:0]        off_rnd;
    logic [PARAM_W+1:0] off_sum, w0_sum, w1_sum;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.step)
            STEP_MUL_A:
            begin
                mul_a = {{14{w0_reg[PARAM_W-1]}}, w0_reg};
                mul_b = {{9{fa_reg[FEAT_W-1]}}, fa_reg};
            end
            STEP_MUL_B:
            begin
                mul_a = {{14{w1_reg[PARAM_W-1]}}, w1_reg};
                mul_b = {{9{fb_reg[FEAT_W-1]}}, fb_reg};
            end
            STEP_SCALE:
            begin
                // z + 2^31 over the table span
                mul_a = {6'b0, ~acc_reg[31], acc_reg[30:0]};
                mul_b = DEPTH_B;
            end
            STEP_INTERP:
            begin
                mul_a = {22'b0, diff_reg};
                mul_b = {9'b0, frac_reg};
            end
            STEP_SLOPE:
            begin
                mul_a = {22'b0, act_reg};
                mul_b = {8'b0, 17'h10000 - {1'b0, act_reg}};
            end
            STEP_GAIN:
            begin
                mul_a = {{17{err_reg[20]}}, err_reg};
                mul_b = {9'b0, gain_reg};
            end
            STEP_SCALE_G:
            begin
                mul_a = prod_reg[37:0];
                mul_b = {10'b0, slope_reg};
            end
            STEP_UPD_A:
            begin
                mul_a = {{3{g_reg[34]}}, g_reg};
                mul_b = {{9{fa_reg[FEAT_W-1]}}, fa_reg};
            end
            STEP_UPD_B:
            begin
                mul_a = {{3{g_reg[34]}}, g_reg};
                mul_b = {{9{fb_reg[FEAT_W-1]}}, fb_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    assign off_shift = {{6{off_reg[PARAM_W-1]}}, off_reg, 12'b0};
    assign in_range  = (acc_reg[41:31] == '0) || (acc_reg[41:31] == '1);
    assign tab_k     = prod_reg[32 +: IW];
    assign tab_k1    = tab_k + 1'b1;

    always_comb
    begin
        priority if (below_reg)
            act_next = sig_tab[0];
        else if (above_reg)
            act_next = sig_tab[DEPTH];
        else
            act_next = lo_reg + prod_reg[31:16];
    end

    // round half up: add half, take the floor
    assign g_rnd   = prod_reg + 63'sd32768;
    assign w_rnd   = prod_reg + 63'sd134217728;
    assign off_rnd = {g_reg[34], g_reg} + 36'd32768;
    assign off_sum = {{2{off_reg[PARAM_W-1]}}, off_reg} + {{6{off_rnd[35]}}, off_rnd[35:16]};
    assign w0_sum  = {{2{w0_reg[PARAM_W-1]}}, w0_reg} + w_rnd[53:28];
    assign w1_sum  = {{2{w1_reg[PARAM_W-1]}}, w1_reg} + w_rnd[53:28];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fa_reg   <= in_feature_a;
            fb_reg   <= in_feature_b;
            tg_reg   <= in_target;
            mode_reg <= in_mode;
        end
        prod_reg <= prod_next;
        unique case (cmd.step)
            STEP_MUL_B:
                acc_reg <= prod_reg[41:0] + off_shift;
            STEP_SUM:
                acc_reg <= acc_reg + prod_reg[41:0];
            STEP_SCALE:
            begin
                below_reg <= !in_range && acc_reg[41];
                above_reg <= !in_range && !acc_reg[41];
            end
            STEP_FETCH:
            begin
                lo_reg   <= sig_tab[tab_k];
                diff_reg <= sig_tab[tab_k1] - sig_tab[tab_k];
                frac_reg <= prod_reg[31:16];
            end
            STEP_ACT:
                act_reg <= act_next;
            STEP_EMIT:
            begin
                out_act_reg <= act_reg;
                out_dec_reg <= act_reg[ACT_W-1];
            end
            STEP_SLOPE:
                err_reg <= {tg_reg[FEAT_W-1], tg_reg, 4'b0} - {5'b0, act_reg};
            STEP_GAIN:
                slope_reg <= prod_reg[30:16];
            STEP_ROUND:
                g_reg <= g_rnd[50:16];
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg        <= '0;
            w1_reg        <= '0;
            off_reg       <= '0;
            gain_reg      <= GAIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_WEIGHT_A: w0_reg   <= cfg_data;
                    REG_WEIGHT_B: w1_reg   <= cfg_data;
                    REG_OFFSET:   off_reg  <= cfg_data;
                    REG_GAIN:     gain_reg <= cfg_data[GAIN_W-1:0];
                endcase
            end
            else
            begin
                unique case (cmd.step)
                    STEP_UPD_A: off_reg <= sat24(off_sum);
                    STEP_UPD_B: w0_reg  <= sat24(w0_sum);
                    STEP_UPD_C: w1_reg  <= sat24(w1_sum);
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.step == STEP_EMIT)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.mode      = mode_reg;
    assign status.slot_free = !out_valid_reg || res_ready;

    assign res_valid      = out_valid_reg;
    assign res_activation = out_act_reg;
    assign res_decision   = out_dec_reg;

endmodule

FILE: sv/sigtrn_ctrl.sv
// Sequencer of the sigmoid trainer: steps the shared multiplier through inference and update.
module sigtrn_ctrl import sigtrn_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_SUM,
        S_SCALE,
        S_FETCH,
        S_INTERP,
        S_ACT,
        S_EMIT,
        S_SLOPE,
        S_GAIN,
        S_SCALE_G,
        S_ROUND,
        S_UPD_A,
        S_UPD_B,
        S_UPD_C
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = STEP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A:   begin cmd.step = STEP_MUL_A;   state_next = S_MUL_B;   end
            S_MUL_B:   begin cmd.step = STEP_MUL_B;   state_next = S_SUM;     end
            S_SUM:     begin cmd.step = STEP_SUM;     state_next = S_SCALE;   end
            S_SCALE:   begin cmd.step = STEP_SCALE;   state_next = S_FETCH;   end
            S_FETCH:   begin cmd.step = STEP_FETCH;   state_next = S_INTERP;  end
            S_INTERP:  begin cmd.step = STEP_INTERP;  state_next = S_ACT;     end
            S_ACT:     begin cmd.step = STEP_ACT;     state_next = S_EMIT;    end
            S_EMIT:
            begin
                // hold until the result slot drains
                if (status.slot_free)
                begin
                    cmd.step   = STEP_EMIT;
                    state_next = status.mode ? S_SLOPE : S_IDLE;
                end
            end
            S_SLOPE:   begin cmd.step = STEP_SLOPE;   state_next = S_GAIN;    end
            S_GAIN:    begin cmd.step = STEP_GAIN;    state_next = S_SCALE_G; end
            S_SCALE_G: begin cmd.step = STEP_SCALE_G; state_next = S_ROUND;   end
            S_ROUND:   begin cmd.step = STEP_ROUND;   state_next = S_UPD_A;   end
            S_UPD_A:   begin cmd.step = STEP_UPD_A;   state_next = S_UPD_B;   end
            S_UPD_B:   begin cmd.step = STEP_UPD_B;   state_next = S_UPD_C;   end
            S_UPD_C:   begin cmd.step = STEP_UPD_C;   state_next = S_IDLE;    end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

FILE: sv/sigmoid_neuron_online_trainer.sv
// Top level of the two-input sigmoid neuron with online delta-rule training.
//
// Channels: 'sample' takes one item per training or inference sample (mode, two Q4.12
// features, Q4.12 target); 'result' returns one item per sample (Q0.16 activation and
// a class bit that is set at one half and above). Both use valid/ready.
// Configuration: cfg_we/cfg_index/cfg_data write the starting weights and offset
// (loaded into the live state at once) and the learning rate. Write only while idle.
// Timing: one multiplier is shared by every product of the forward pass and the
// update, one product per cycle while the emit step is not held. A result item is
// registered after the steps MUL_A to EMIT. An inference item holds the block up to
// EMIT, a training item up to UPD_C; the next sample is taken only once back in idle.
// Stall: a result waits in an output register; the following sample is still taken
// and worked on, and its result waits in the sequencer until the register drains.
// Reset: weights and offset clear to zero, learning rate to 6554, no result pending.
// The sigmoid table has SIGMOID_TABLE_DEPTH+1 points, built at elaboration.
module sigmoid_neuron_online_trainer import sigtrn_pkg::*; #(
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sigtrn_in_if.sink            sample,
    sigtrn_out_if.source         result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PARAM_W-1:0]   cfg_data
);

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    sigtrn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sigtrn_dp #(
        .DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_mode        (sample.mode),
        .in_feature_a   (sample.feature_a),
        .in_feature_b   (sample.feature_b),
        .in_target      (sample.target),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .res_valid      (result.valid),
        .res_ready      (result.ready),
        .res_activation (result.activation),
        .res_decision   (result.decision)
    );

    assign sample.ready = in_ready;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("sample taken while an item is still in work");

    a_update_only_training: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == STEP_UPD_A || cmd.step == STEP_UPD_B || cmd.step == STEP_UPD_C)
            |-> status.mode)
        else $error("weight update issued for an inference item");

    a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |-> ##9 result.valid)
        else $error("no result pending nine cycles after a sample");

endmodule

FILE: tb/sigtrn_checker.sv
// Scoreboard for the sigmoid trainer: mirrors the neuron state, predicts each result item and compares.
`timescale 1ns / 1ps
module sigtrn_checker import sigtrn_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sigtrn_in_if                 smp,
    sigtrn_out_if                res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PARAM_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   awaited,
    output int                   clamp_hits,
    output int                   rail_hits
);

    localparam longint unsigned Q31_ONE   = 64'd1 << 31;
    localparam longint          W_TOP     = 64'sd8388607;
    localparam longint          W_BOTTOM  = -64'sd8388608;
    localparam longint          Z_RAIL    = 64'sd1 <<< 31;

    typedef struct packed {
        logic [ACT_W-1:0] activation;
        logic             decision;
    } outcome_t;

    longint unsigned sig_points [0:TABLE_DEPTH];
    longint          weight_a;
    longint          weight_b;
    longint          offset;
    longint          gain;
    outcome_t        awaited_q [$];
    int              mismatches;
    int              checked;
    int              clamps;
    int              rails;

    // Sigmoid points at x = -8 + 16k/depth; e^-x from a series at |x|/16, squared four times
    initial
    begin
        longint          k;
        longint          a;
        longint unsigned mag;
        longint unsigned u;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned den;
        longint unsigned s;
        int              n;
        mismatches = 0;
        checked    = 0;
        clamps     = 0;
        rails      = 0;
        for (k = 0; k <= TABLE_DEPTH; k++)
        begin
            a    = 2 * k - TABLE_DEPTH;
            mag  = (a < 0) ? -a : a;
            u    = (mag << 31) / (2 * TABLE_DEPTH);
            term = Q31_ONE;
            acc  = Q31_ONE;
            for (n = 1; n <= 14; n++)
            begin
                term = ((term * u) >> 31) / n;
                if (n % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            repeat (4) acc = (acc * acc) >> 31;
            den = Q31_ONE + acc;
            if (a >= 0)
                s = ((64'd1 << 47) + den / 2) / den;
            else
                s = ((acc << 16) + den / 2) / den;
            sig_points[k] = (s > 65535) ? 65535 : s;
        end
    end

    // Round half up: floor of (v + half) / 2^s
    function automatic longint round_half_up(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint saturate(longint v);
        if (v > W_TOP)
        begin
            clamps++;
            return W_TOP;
        end
        if (v < W_BOTTOM)
        begin
            clamps++;
            return W_BOTTOM;
        end
        return v;
    endfunction

    // Forward pass on the current state, then the delta-rule update when learning
    function automatic outcome_t infer_and_learn(logic learn, logic [FEAT_W-1:0] a_raw,
                                                 logic [FEAT_W-1:0] b_raw,
                                                 logic [FEAT_W-1:0] t_raw);
        longint   fa;
        longint   fb;
        longint   tg;
        longint   z;
        longint   scaled;
        longint   pos;
        longint   frac;
        longint   lo;
        longint   hi;
        longint   act;
        longint   err;
        longint   slope;
        longint   g;
        outcome_t o;
        fa = $signed(a_raw);
        fb = $signed(b_raw);
        tg = $signed(t_raw);
        z  = fa * weight_a + fb * weight_b + offset * 4096;
        if (z <= -Z_RAIL)
        begin
            act = sig_points[0];
            rails++;
        end
        else if (z >= Z_RAIL)
        begin
            act = sig_points[TABLE_DEPTH];
            rails++;
        end
        else
        begin
            scaled = (z + Z_RAIL) * TABLE_DEPTH;
            pos    = scaled >>> 32;
            frac   = (scaled >>> 16) % 65536;
            lo     = sig_points[pos];
            hi     = sig_points[pos + 1];
            act    = lo + (((hi - lo) * frac) >>> 16);
        end
        o.activation = act[ACT_W-1:0];
        o.decision   = (act >= 32768);
        if (learn)
        begin
            err      = tg * 16 - act;
            slope    = (act * (65536 - act)) >>> 16;
            g        = round_half_up(gain * err * slope, 16);
            weight_a = saturate(weight_a + round_half_up(g * fa, 28));
            weight_b = saturate(weight_b + round_half_up(g * fb, 28));
            offset   = saturate(offset + round_half_up(g, 16));
        end
        return o;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] result item %0d: %s", $time, checked, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            weight_a = 0;
            weight_b = 0;
            offset   = 0;
            gain     = GAIN_RESET;
            awaited_q.delete();
        end
        else
        begin
            // A preset goes straight into the live state as well
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_WEIGHT_A: weight_a = $signed(cfg_data);
                    REG_WEIGHT_B: weight_b = $signed(cfg_data);
                    REG_OFFSET:   offset   = $signed(cfg_data);
                    REG_GAIN:     gain     = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (smp.valid && smp.ready)
                awaited_q.insert(awaited_q.size(),
                                 infer_and_learn(smp.mode, smp.feature_a,
                                                 smp.feature_b, smp.target));
            if (res.valid && res.ready)
            begin
                if (awaited_q.size() == 0)
                    report_mismatch("result item with nothing awaited");
                else
                begin
                    want = awaited_q.pop_front();
                    if (res.activation !== want.activation)
                        report_mismatch($sformatf("activation %0d, predicted %0d",
                                                  res.activation, want.activation));
                    if (res.decision !== want.decision)
                        report_mismatch($sformatf("decision %b, predicted %b",
                                                  res.decision, want.decision));
                end
                checked++;
            end
        end
        fail_count <= mismatches;
        awaited    <= awaited_q.size();
        clamp_hits <= clamps;
        rail_hits  <= rails;
    end

endmodule

FILE: tb/tb_sigmoid_neuron_online_trainer.sv
// Testbench top for the sigmoid trainer: stimulus, configuration, result back-pressure and verdict.
`timescale 1ns / 1ps
module tb_sigmoid_neuron_online_trainer import sigtrn_pkg::*; ();

    localparam int TABLE_DEPTH   = 256;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 80;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 175;
    localparam int SET_SIZE      = 6;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PARAM_W-1:0]   cfg_data;
    int                   fail_count;
    int                   awaited;
    int                   clamp_hits;
    int                   rail_hits;
    int                   cycle_count;
    int                   samples_sent;
    int                   trainings_sent;
    int                   settings_loaded;
    int                   holds_asked;
    int                   holds_given;
    bit                   calm;

    sigtrn_in_if  smp_if ();
    sigtrn_out_if res_if ();

    sigmoid_neuron_online_trainer #(
        .SIGMOID_TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sigtrn_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .smp        (smp_if),
        .res        (res_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .awaited    (awaited),
        .clamp_hits (clamp_hits),
        .rail_hits  (rail_hits)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Random sender gaps; stretches of 40 items alternate between none, few and many
    task automatic pause_sender();
        int gap;
        gap = 0;
        if (!calm)
        begin
            case ((samples_sent / 40) % 3)
                1: if ($urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
                2: if ($urandom_range(0, 1) == 0) gap = $urandom_range(1, 8);
                default: ;
            endcase
        end
        if (gap > 0)
        begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic offer_sample(logic m, logic [FEAT_W-1:0] a, logic [FEAT_W-1:0] b,
                                logic [FEAT_W-1:0] t);
        smp_if.valid     <= 1'b1;
        smp_if.mode      <= m;
        smp_if.feature_a <= a;
        smp_if.feature_b <= b;
        smp_if.target    <= t;
        do @(posedge clk); while (!smp_if.ready);
        samples_sent++;
        if (m)
            trainings_sent++;
        pause_sender();
    endtask

    // Hold the sender until every result is back, then let a trailing update finish
    task automatic drain_block();
        smp_if.valid <= 1'b0;
        do @(posedge clk); while (awaited != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_setting(logic [PARAM_W-1:0] wa, logic [PARAM_W-1:0] wb,
                                logic [PARAM_W-1:0] off, logic [GAIN_W-1:0] g);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WEIGHT_A;
        cfg_data  <= wa;
        @(posedge clk);
        cfg_index <= REG_WEIGHT_B;
        cfg_data  <= wb;
        @(posedge clk);
        cfg_index <= REG_OFFSET;
        cfg_data  <= off;
        @(posedge clk);
        // upper byte is junk that the block must drop
        cfg_index <= REG_GAIN;
        cfg_data  <= {8'($urandom_range(0, 255)), g};
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    initial
    begin
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, awaited);
        $display("tb_sigmoid_neuron_online_trainer failed");
        $finish;
    end

    // Result side: short random stalls, and a long hold whenever one is asked for
    initial
    begin
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_given)
            begin
                holds_given++;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                res_if.ready <= 1'b1;
            end
            else if (!calm && (cycle_count / 64) % 3 != 0 && $urandom_range(0, 4) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                res_if.ready <= 1'b1;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    initial
    begin
        logic [FEAT_W-1:0]  set_a [SET_SIZE];
        logic [FEAT_W-1:0]  set_b [SET_SIZE];
        logic [FEAT_W-1:0]  set_t [SET_SIZE];
        logic [PARAM_W-1:0] wa;
        logic [PARAM_W-1:0] wb;
        logic [PARAM_W-1:0] off;
        logic [GAIN_W-1:0]  g;
        int                 phase;
        int                 n;
        int                 i;
        int                 pick;
        int                 sa;
        int                 sb;
        int                 rule_a;
        int                 rule_b;

        cycle_count      = 0;
        samples_sent     = 0;
        trainings_sent   = 0;
        settings_loaded  = 0;
        holds_asked      = 0;
        holds_given      = 0;
        calm             = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_WEIGHT_A;
        cfg_data         = '0;
        smp_if.valid     = 1'b0;
        smp_if.mode      = 1'b0;
        smp_if.feature_a = '0;
        smp_if.feature_b = '0;
        smp_if.target    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: zero input lands exactly on one half
        offer_sample(1'b0, 16'h0000, 16'h0000, 16'h0000);
        offer_sample(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF);
        offer_sample(1'b1, 16'h8000, 16'h7FFF, 16'h8000);
        offer_sample(1'b0, 16'h0001, 16'hFFFF, 16'h0000);
        drain_block();

        // A tiny negative offset drops the activation just under one half
        load_setting(24'h000000, 24'h000000, 24'hFFFFFF, 16'd6554);
        offer_sample(1'b0, 16'h0000, 16'h0000, 16'h0000);
        offer_sample(1'b1, 16'h1000, 16'hF000, 16'h1000);
        drain_block();

        // Opposite extreme weights: both table rails, then weights driven into their limits
        load_setting(24'h7FFFFF, 24'h800000, 24'h000000, 16'hFFFF);
        offer_sample(1'b0, 16'h7FFF, 16'h0000, 16'h0000);
        offer_sample(1'b0, 16'h8000, 16'h0000, 16'h0000);
        offer_sample(1'b0, 16'h0000, 16'h7FFF, 16'h0000);
        offer_sample(1'b1, 16'h1000, 16'h1000, 16'h7FFF);
        offer_sample(1'b1, 16'h1000, 16'h1000, 16'h8000);
        drain_block();

        // Offset pinned at either end and pushed further out
        load_setting(24'h000000, 24'h000000, 24'h7FFFFF, 16'hFFFF);
        offer_sample(1'b1, 16'h0000, 16'h0000, 16'h7FFF);
        offer_sample(1'b1, 16'hFFFF, 16'h0001, 16'h7FFF);
        drain_block();
        load_setting(24'h000000, 24'h000000, 24'h800000, 16'hFFFF);
        offer_sample(1'b1, 16'h0000, 16'h0000, 16'h8000);
        offer_sample(1'b1, 16'h5555, 16'hAAAA, 16'h8000);
        drain_block();

        for (phase = 0; phase < PHASES; phase++)
        begin
            wa = 24'($urandom_range(0, 262143) - 131072);
            wb = 24'($urandom_range(0, 262143) - 131072);
            off = 24'($urandom_range(0, 262143) - 131072);
            g = 16'($urandom);
            case (phase)
                0:
                begin
                    wa  = '0;
                    wb  = '0;
                    off = '0;
                end
                2:
                begin
                    // no learning: weights must hold still under training items
                    wa  = 24'h800000;
                    wb  = 24'h7FFFFF;
                    off = 24'($urandom);
                    g   = 16'h0000;
                end
                3:
                begin
                    wa  = 24'($urandom);
                    wb  = 24'($urandom);
                    off = 24'($urandom);
                    g   = 16'd6554;
                end
                4:
                begin
                    off = 24'h7FFFFF;
                    g   = 16'hFFFF;
                end
                default: ;
            endcase
            load_setting(wa, wb, off, g);

            // A small linearly separable set, replayed as epochs
            rule_a = $urandom_range(0, 1) ? 1 : -1;
            rule_b = $urandom_range(0, 1) ? 1 : -1;
            for (i = 0; i < SET_SIZE; i++)
            begin
                sa = $urandom_range(0, 32767) - 16384;
                sb = $urandom_range(0, 32767) - 16384;
                set_a[i] = 16'(sa);
                set_b[i] = 16'(sb);
                set_t[i] = (rule_a * sa + rule_b * sb > 0) ? 16'h1000 : 16'h0000;
            end

            if (phase == PHASES - 1)
                calm = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 2 && n == 60)
                    holds_asked++;
                if (phase == 3 && n == 90)
                    drain_block();
                if ($urandom_range(0, 4) == 0)
                    offer_sample(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                else
                begin
                    pick = $urandom_range(0, SET_SIZE - 1);
                    offer_sample($urandom_range(0, 6) != 0, set_a[pick], set_b[pick],
                                 set_t[pick]);
                end
            end
            drain_block();
        end

        $display("ran %0d samples (%0d training) under %0d register settings",
                 samples_sent, trainings_sent, settings_loaded);
        $display("weights or offset saturated %0d times, activation on a table rail %0d times",
                 clamp_hits, rail_hits);
        if (fail_count == 0 && awaited == 0)
            $display("tb_sigmoid_neuron_online_trainer passed");
        else
            $display("tb_sigmoid_neuron_online_trainer failed");
        $finish;
    end

endmodule

FILE: sigmoid_neuron_online_trainer.f
sv/sigtrn_pkg.sv
sv/sigtrn_if.sv
sv/sigtrn_dp.sv
sv/sigtrn_ctrl.sv
sv/sigmoid_neuron_online_trainer.sv
tb/sigtrn_checker.sv
tb/tb_sigmoid_neuron_online_trainer.sv
